/* rtl/lpmd_pkg.sv */
`timescale 1ns / 1ps

package lpmd_pkg;

	localparam int HEADER_BYTES = 16;

	localparam logic [6:0] HDR_LAST  = 7'(HEADER_BYTES - 1);
	localparam logic [6:0] ID_END    = 7'd4;
	localparam logic [6:0] PAY_END   = 7'd8;
	localparam logic [6:0] EXT_START = 7'd9;
	localparam logic [6:0] EXT_END   = 7'd13;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_EXT    = 2'd1;
	localparam logic [1:0] PH_PAY    = 2'd2;

	localparam logic [1:0] KIND_EXT   = 2'd0;
	localparam logic [1:0] KIND_PAY   = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

endpackage

/* rtl/length_prefixed_message_deframer.sv */
`timescale 1ns / 1ps

// channel   valid        stall        payload
// input     data_valid   data_stall   data_byte
// output    item_valid   item_stall   item_kind, frame_id, value, has_extend,
//                                     last_of_message
//
// One byte per cycle while data_stall is low. A byte waits in the input register
// until the parse logic can write any result from it into the output register.
// Header bytes other than the last of an empty message give no result.
// arst_n clears the parser to the start of a header and empties both registers.
// A stalled output register holds a full input register; data_stall follows
// item_stall in the same cycle, so no transfer is lost.

module length_prefixed_message_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	output logic        item_valid,
	input  logic        item_stall,
	output logic [1:0]  item_kind,
	output logic [31:0] frame_id,
	output logic [7:0]  value,
	output logic        has_extend,
	output logic        last_of_message
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [1:0]  phase_q;
	logic [6:0]  header_index_q;
	logic [31:0] id_shift_q;
	logic [31:0] payload_length_q;
	logic [31:0] extend_length_q;
	logic [31:0] bytes_left_q;
	logic        item_valid_q;
	logic [1:0]  item_kind_q;
	logic [31:0] frame_id_q;
	logic [7:0]  value_q;
	logic        has_extend_q;
	logic        last_q;

	logic        advance;
	logic        fire;
	logic [1:0]  phase_d;
	logic [6:0]  header_index_d;
	logic [31:0] id_shift_d;
	logic [31:0] payload_length_d;
	logic [31:0] extend_length_d;
	logic [31:0] bytes_left_d;
	logic [31:0] left_dec;
	logic [31:0] pl_base;
	logic [31:0] ext_base;
	logic        emit;
	logic [1:0]  kind_d;
	logic [7:0]  value_d;
	logic        last_d;

	assign advance    = !item_valid_q || !item_stall;
	assign fire       = valid_s1 && advance;
	assign data_stall = valid_s1 && !advance;
	assign left_dec   = bytes_left_q - 32'd1;
	assign pl_base    = (header_index_q == 7'd0) ? 32'd0 : payload_length_q;
	assign ext_base   = (header_index_q == 7'd0) ? 32'd0 : extend_length_q;

	always_comb begin
		phase_d          = phase_q;
		header_index_d   = header_index_q;
		id_shift_d       = id_shift_q;
		payload_length_d = payload_length_q;
		extend_length_d  = extend_length_q;
		bytes_left_d     = bytes_left_q;
		emit             = 1'b0;
		kind_d           = lpmd_pkg::KIND_EXT;
		value_d          = byte_s1;
		last_d           = 1'b0;
		case (phase_q)
			lpmd_pkg::PH_EXT: begin
				emit         = 1'b1;
				kind_d       = lpmd_pkg::KIND_EXT;
				bytes_left_d = left_dec;
				if (left_dec == 32'd0) begin
					if (payload_length_q != 32'd0) begin
						phase_d      = lpmd_pkg::PH_PAY;
						bytes_left_d = payload_length_q;
					end else begin
						phase_d = lpmd_pkg::PH_HEADER;
						last_d  = 1'b1;
					end
				end
			end
			lpmd_pkg::PH_PAY: begin
				emit         = 1'b1;
				kind_d       = lpmd_pkg::KIND_PAY;
				bytes_left_d = left_dec;
				if (left_dec == 32'd0) begin
					phase_d = lpmd_pkg::PH_HEADER;
					last_d  = 1'b1;
				end
			end
			default: begin
				phase_d          = lpmd_pkg::PH_HEADER;
				payload_length_d = pl_base;
				extend_length_d  = ext_base;
				if (header_index_q < lpmd_pkg::ID_END) begin
					id_shift_d = {id_shift_q[23:0], byte_s1};
				end else if (header_index_q < lpmd_pkg::PAY_END) begin
					payload_length_d = {pl_base[23:0], byte_s1};
				end else if (header_index_q >= lpmd_pkg::EXT_START &&
				             header_index_q < lpmd_pkg::EXT_END) begin
					extend_length_d = {ext_base[23:0], byte_s1};
				end
				if (header_index_q >= lpmd_pkg::HDR_LAST) begin
					header_index_d = 7'd0;
					if (extend_length_d != 32'd0) begin
						phase_d      = lpmd_pkg::PH_EXT;
						bytes_left_d = extend_length_d;
					end else if (payload_length_d != 32'd0) begin
						phase_d      = lpmd_pkg::PH_PAY;
						bytes_left_d = payload_length_d;
					end else begin
						emit    = 1'b1;
						kind_d  = lpmd_pkg::KIND_EMPTY;
						value_d = 8'd0;
						last_d  = 1'b1;
					end
				end else begin
					header_index_d = header_index_q + 7'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!data_stall && data_valid) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= lpmd_pkg::PH_HEADER;
			header_index_q   <= 7'd0;
			id_shift_q       <= 32'd0;
			payload_length_q <= 32'd0;
			extend_length_q  <= 32'd0;
			bytes_left_q     <= 32'd0;
		end else if (fire) begin
			phase_q          <= phase_d;
			header_index_q   <= header_index_d;
			id_shift_q       <= id_shift_d;
			payload_length_q <= payload_length_d;
			extend_length_q  <= extend_length_d;
			bytes_left_q     <= bytes_left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
		end else if (advance) begin
			item_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			item_kind_q  <= kind_d;
			frame_id_q   <= id_shift_d;
			value_q      <= value_d;
			has_extend_q <= extend_length_d != 32'd0;
			last_q       <= last_d;
		end
	end

	assign item_valid      = item_valid_q;
	assign item_kind       = item_kind_q;
	assign frame_id        = frame_id_q;
	assign value           = value_q;
	assign has_extend      = has_extend_q;
	assign last_of_message = last_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> (item_valid_q && item_stall))
		else $error("input stalled without output backpressure");

	a_region_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lpmd_pkg::PH_EXT || phase_q == lpmd_pkg::PH_PAY) |->
		(bytes_left_q != 32'd0))
		else $error("body phase with no bytes left");

	a_header_index: assert property (@(posedge clk) disable iff (!arst_n)
		header_index_q <= lpmd_pkg::HDR_LAST)
		else $error("header index overrun");

	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid_q && item_kind_q == lpmd_pkg::KIND_EMPTY) |->
		(last_q && value_q == 8'd0 && !has_extend_q))
		else $error("malformed empty marker");

	a_body_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit && last_d) |=> (phase_q == lpmd_pkg::PH_HEADER))
		else $error("last item did not return to header");

endmodule
